/* rtl/vst_pkg.sv */
package vst_pkg;

	localparam int LEN_W   = 12;
	localparam int LINE_W  = 8;
	localparam int HB_W    = 13;
	localparam int VB_W    = 20;
	localparam int ANY_W   = 17;
	localparam int TOTAL_W = 32;
	localparam int REM_W   = 9;
	localparam int PROD_W  = REM_W + LEN_W;

	localparam logic [LEN_W-1:0]  RST_CYCLES_PER_LINE = 12'd1232;
	localparam logic [LEN_W-1:0]  RST_HBLANK_START    = 12'd960;
	localparam logic [LINE_W-1:0] RST_TOTAL_LINES     = 8'd228;
	localparam logic [LINE_W-1:0] RST_VISIBLE_LINES   = 8'd160;

	localparam logic [ANY_W-1:0] TIMER_BOUND = 17'h10000;
	localparam logic [VB_W-1:0]  VBLANK_MAX  = 20'hFFFFF;

	localparam logic [1:0] REG_CYCLES_PER_LINE = 2'd0;
	localparam logic [1:0] REG_HBLANK_START    = 2'd1;
	localparam logic [1:0] REG_TOTAL_LINES     = 2'd2;
	localparam logic [1:0] REG_VISIBLE_LINES   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS,
		ST_LINE,
		ST_WRAP,
		ST_VREM,
		ST_MUL,
		ST_DONE
	} vst_state_t;

endpackage

/* rtl/vst_div.sv */
module vst_div import vst_pkg::*; #(
	parameter int DW = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW-1:0]    dividend,
	input  logic [LEN_W-1:0] divisor,
	output logic             done,
	output logic [DW-1:0]    quotient,
	output logic [LEN_W-1:0] remainder
);

	localparam int CW = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DW-1:0]    quo_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] dvs_q;
	logic [LEN_W:0]   rem_shift;
	logic             fits;

	assign rem_shift = {rem_q, quo_q[DW-1]};
	assign fits      = rem_shift >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= LEN_W'(rem_shift - {1'b0, dvs_q});
			end else begin
				rem_q <= rem_shift[LEN_W-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/video_scanline_timing.sv */
// The shared restoring divider runs twice per request, one quotient bit per cycle, on a
// dividend of W = max(ADVANCE_BITS, 12) + 1 bits, first for the line wrap and then for the frame wrap.
// A new request is taken only once the last result is loaded, which a stalled result holds off;
// in_stall is high while a request is in work or its result waits.
// Reset: arst_n clears the beam position and cycle total and loads the default timing.
module video_scanline_timing import vst_pkg::*; #(
	parameter int ADVANCE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ADVANCE_BITS-1:0] advance_cycles,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [TOTAL_W-1:0]      total_count,
	output logic [LINE_W-1:0]       line_number,
	output logic [LEN_W-1:0]        line_position,
	output logic                    in_vblank,
	output logic                    in_hblank,
	output logic [HB_W-1:0]         until_hblank,
	output logic [VB_W-1:0]         until_vblank,
	output logic [VB_W-1:0]         until_video_event,
	output logic [ANY_W-1:0]        until_any_event
);

	localparam int PW = (ADVANCE_BITS > LEN_W ? ADVANCE_BITS : LEN_W) + 1;

	vst_state_t state_q, state_d;

	logic [LEN_W-1:0]  cpl_q, hbs_q;
	logic [LINE_W-1:0] tl_q, vis_q;
	logic [LEN_W-1:0]  len_eff;
	logic [LINE_W-1:0] cnt_eff;

	logic [TOTAL_W-1:0] cycle_total_q;
	logic [LEN_W-1:0]   line_offset_q;
	logic [LINE_W-1:0]  line_index_q;
	logic               lines_nz_q;
	logic [LINE_W-1:0]  lmod_q;
	logic [HB_W-1:0]    hb_q;
	logic [REM_W-1:0]   rem_q;
	logic [PROD_W-1:0]  prod_q;

	logic               cfg_wr;
	logic               in_acc;
	logic               out_load;

	logic               div_start;
	logic               div_done;
	logic [PW-1:0]      div_dividend;
	logic [LEN_W-1:0]   div_divisor;
	logic [PW-1:0]      div_quot;
	logic [LEN_W-1:0]   div_rem;
	logic [PW-1:0]      line_div_in;

	logic [LINE_W-1:0]  wrap_base;
	logic [LINE_W:0]    wrap_sum;
	logic [LINE_W:0]    wrap_line;
	logic [HB_W:0]      hb_calc;
	logic signed [10:0] rem_calc;
	logic signed [PROD_W+1:0] vb_diff;
	logic [VB_W-1:0]    vb_val;
	logic [VB_W-1:0]    video_val;
	logic [ANY_W-1:0]   any_val;

	logic               out_valid_q;
	logic [TOTAL_W-1:0] total_q;
	logic [LINE_W-1:0]  line_q;
	logic [LEN_W-1:0]   pos_q;
	logic               vbl_q, hbl_q;
	logic [HB_W-1:0]    uhb_q;
	logic [VB_W-1:0]    uvb_q, uvid_q;
	logic [ANY_W-1:0]   uany_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpl_q <= RST_CYCLES_PER_LINE;
			hbs_q <= RST_HBLANK_START;
			tl_q  <= RST_TOTAL_LINES;
			vis_q <= RST_VISIBLE_LINES;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CYCLES_PER_LINE: cpl_q <= pwdata[LEN_W-1:0];
				REG_HBLANK_START:    hbs_q <= pwdata[LEN_W-1:0];
				REG_TOTAL_LINES:     tl_q  <= pwdata[LINE_W-1:0];
				REG_VISIBLE_LINES:   vis_q <= pwdata[LINE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CYCLES_PER_LINE: prdata = 32'(cpl_q);
			REG_HBLANK_START:    prdata = 32'(hbs_q);
			REG_TOTAL_LINES:     prdata = 32'(tl_q);
			REG_VISIBLE_LINES:   prdata = 32'(vis_q);
		endcase
	end

	assign len_eff = (cpl_q == '0) ? LEN_W'(1) : cpl_q;
	assign cnt_eff = (tl_q == '0) ? LINE_W'(1) : tl_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_acc    = 1'b0;
		out_load  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					in_acc    = 1'b1;
					div_start = 1'b1;
					state_d   = ST_POS;
				end
			end
			ST_POS: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_LINE;
				end
			end
			ST_LINE: begin
				if (div_done) begin
					state_d = ST_WRAP;
				end
			end
			ST_WRAP: state_d = ST_VREM;
			ST_VREM: state_d = ST_MUL;
			ST_MUL:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// shared divider: line length first, then frame length
	assign line_div_in  = (line_index_q >= cnt_eff) ? div_quot - 1'b1 : div_quot;
	assign div_dividend = (state_q == ST_IDLE)
		? PW'(line_offset_q) + PW'(advance_cycles) : line_div_in;
	assign div_divisor  = (state_q == ST_IDLE) ? len_eff : LEN_W'(cnt_eff);

	vst_div #(.DW(PW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign wrap_base = (line_index_q >= cnt_eff) ? '0 : line_index_q;
	assign wrap_sum  = {1'b0, wrap_base} + {1'b0, lmod_q};
	assign wrap_line = (wrap_sum >= {1'b0, cnt_eff}) ? wrap_sum - {1'b0, cnt_eff} : wrap_sum;

	assign hb_calc = (line_offset_q >= hbs_q)
		? (HB_W+1)'(len_eff) - (HB_W+1)'(line_offset_q) + (HB_W+1)'(hbs_q)
		: (HB_W+1)'(hbs_q) - (HB_W+1)'(line_offset_q);

	always_comb begin
		if (line_index_q >= vis_q) begin
			rem_calc = $signed({3'b0, tl_q}) - $signed({3'b0, line_index_q})
				+ $signed({3'b0, vis_q});
		end else begin
			rem_calc = $signed({3'b0, vis_q}) - $signed({3'b0, line_index_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_total_q <= '0;
			line_offset_q <= '0;
			line_index_q  <= '0;
		end else begin
			if (in_acc) begin
				cycle_total_q <= cycle_total_q + TOTAL_W'(advance_cycles);
			end
			if (state_q == ST_POS && div_done) begin
				line_offset_q <= div_rem;
			end
			if (state_q == ST_WRAP && lines_nz_q) begin
				line_index_q <= wrap_line[LINE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_POS && div_done) begin
			lines_nz_q <= |div_quot;
		end
		if (state_q == ST_LINE && div_done) begin
			lmod_q <= div_rem[LINE_W-1:0];
		end
		if (state_q == ST_WRAP) begin
			hb_q <= hb_calc[HB_W-1:0];
		end
		if (state_q == ST_VREM) begin
			rem_q <= rem_calc[10] ? '0 : rem_calc[REM_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(rem_q * len_eff);
		end
	end

	assign vb_diff = $signed({2'b0, prod_q}) - $signed((PROD_W+2)'(line_offset_q));

	always_comb begin
		if (vb_diff[PROD_W+1]) begin
			vb_val = '0;
		end else if (vb_diff[PROD_W:0] > (PROD_W+1)'(VBLANK_MAX)) begin
			vb_val = VBLANK_MAX;
		end else begin
			vb_val = vb_diff[VB_W-1:0];
		end
		video_val = (VB_W'(hb_q) < vb_val) ? VB_W'(hb_q) : vb_val;
		if (video_val >= VB_W'(TIMER_BOUND)) begin
			any_val = TIMER_BOUND;
		end else if (video_val == '0) begin
			any_val = ANY_W'(1);
		end else begin
			any_val = video_val[ANY_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			total_q <= cycle_total_q;
			line_q  <= line_index_q;
			pos_q   <= line_offset_q;
			vbl_q   <= line_index_q >= vis_q;
			hbl_q   <= line_offset_q >= hbs_q;
			uhb_q   <= hb_q;
			uvb_q   <= vb_val;
			uvid_q  <= video_val;
			uany_q  <= any_val;
		end
	end

	assign out_valid         = out_valid_q;
	assign total_count       = total_q;
	assign line_number       = line_q;
	assign line_position     = pos_q;
	assign in_vblank         = vbl_q;
	assign in_hblank         = hbl_q;
	assign until_hblank      = uhb_q;
	assign until_vblank      = uvb_q;
	assign until_video_event = uvid_q;
	assign until_any_event   = uany_q;

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_POS)
		else $error("accepted request did not start the divider");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_POS || state_q == ST_LINE)
		else $error("divider finished outside a divide state");

	a_any_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> until_any_event != '0 && until_any_event <= TIMER_BOUND)
		else $error("until_any_event out of range");

	a_video_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> until_video_event <= until_vblank)
		else $error("video event later than vblank");
`endif

endmodule

/* verif/testbench.sv */
module testbench;
	import vst_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADV_W = 16;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_count;
		logic [LINE_W-1:0]  line_number;
		logic [LEN_W-1:0]   line_position;
		logic               in_vblank;
		logic               in_hblank;
		logic [HB_W-1:0]    until_hblank;
		logic [VB_W-1:0]    until_vblank;
		logic [VB_W-1:0]    until_video_event;
		logic [ANY_W-1:0]   until_any_event;
	} beam_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [ADV_W-1:0]   advance_cycles = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [TOTAL_W-1:0] total_count;
	logic [LINE_W-1:0]  line_number;
	logic [LEN_W-1:0]   line_position;
	logic               in_vblank;
	logic               in_hblank;
	logic [HB_W-1:0]    until_hblank;
	logic [VB_W-1:0]    until_vblank;
	logic [VB_W-1:0]    until_video_event;
	logic [ANY_W-1:0]   until_any_event;

	// timing registers as the block should hold them
	logic [LEN_W-1:0]   cfg_cpl = RST_CYCLES_PER_LINE;
	logic [LEN_W-1:0]   cfg_hbs = RST_HBLANK_START;
	logic [LINE_W-1:0]  cfg_tl = RST_TOTAL_LINES;
	logic [LINE_W-1:0]  cfg_vis = RST_VISIBLE_LINES;

	// beam state
	logic [31:0]        beam_total = '0;
	logic [15:0]        beam_off = '0;
	logic [7:0]         beam_line = '0;

	logic [ADV_W-1:0]   advance_q[$];
	beam_t              beam_q[$];
	beam_t              want_r;
	int                 errors = 0;
	int                 gap_left = 0;
	int                 stall_left = 0;
	bit                 no_idle = 1'b0;

	video_scanline_timing #(.ADVANCE_BITS(ADV_W)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.advance_cycles(advance_cycles),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.total_count(total_count),
		.line_number(line_number),
		.line_position(line_position),
		.in_vblank(in_vblank),
		.in_hblank(in_hblank),
		.until_hblank(until_hblank),
		.until_vblank(until_vblank),
		.until_video_event(until_video_event),
		.until_any_event(until_any_event)
	);

	always #6 clk = ~clk;

	function automatic beam_t advance_beam(input logic [ADV_W-1:0] adv);
		logic [31:0] len, cnt, pos, lines, line, hb, vbu, video, any;
		longint      rem, vb, tl_l, vis_l, line_l, len_l, off_l;
		beam_t       r;
		len = (cfg_cpl == 0) ? 32'd1 : 32'(cfg_cpl);
		cnt = (cfg_tl == 0) ? 32'd1 : 32'(cfg_tl);
		beam_total = beam_total + 32'(adv);
		pos = 32'(beam_off) + 32'(adv);
		lines = pos / len;
		pos = pos % len;
		line = 32'(beam_line);
		if (lines != 0) begin
			if (line >= cnt) begin
				line = 0;
				lines = lines - 1;
			end
			line = (line + lines % cnt) % cnt;
		end
		beam_off = pos[15:0];
		beam_line = line[7:0];

		if (32'(beam_off) >= 32'(cfg_hbs))
			hb = len - 32'(beam_off) + 32'(cfg_hbs);
		else
			hb = 32'(cfg_hbs) - 32'(beam_off);
		hb = hb & 32'h1FFF;

		tl_l = cfg_tl;
		vis_l = cfg_vis;
		line_l = beam_line;
		len_l = len;
		off_l = beam_off;
		if (beam_line >= cfg_vis)
			rem = tl_l - line_l + vis_l;
		else
			rem = vis_l - line_l;
		if (rem < 0)
			rem = 0;
		vb = rem * len_l - off_l;
		if (vb < 0)
			vb = 0;
		if (vb > 64'd1048575)
			vb = 64'd1048575;
		vbu = 32'(vb);
		video = (hb < vbu) ? hb : vbu;
		any = (video < 32'd65536) ? video : 32'd65536;
		if (any == 0)
			any = 1;

		r.total_count = beam_total;
		r.line_number = beam_line;
		r.line_position = beam_off[LEN_W-1:0];
		r.in_vblank = (beam_line >= cfg_vis);
		r.in_hblank = (32'(beam_off) >= 32'(cfg_hbs));
		r.until_hblank = hb[HB_W-1:0];
		r.until_vblank = vbu[VB_W-1:0];
		r.until_video_event = video[VB_W-1:0];
		r.until_any_event = any[ANY_W-1:0];
		return r;
	endfunction

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_CYCLES_PER_LINE: cfg_cpl = value[LEN_W-1:0];
			REG_HBLANK_START:    cfg_hbs = value[LEN_W-1:0];
			REG_TOTAL_LINES:     cfg_tl = value[LINE_W-1:0];
			REG_VISIBLE_LINES:   cfg_vis = value[LINE_W-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_timing(input logic [11:0] cpl, input logic [11:0] hbs,
			input logic [7:0] tl, input logic [7:0] vis);
		apb_write(REG_CYCLES_PER_LINE, 32'(cpl));
		apb_write(REG_HBLANK_START, 32'(hbs));
		apb_write(REG_TOTAL_LINES, 32'(tl));
		apb_write(REG_VISIBLE_LINES, 32'(vis));
	endtask

	// hold off until every request is taken and every result is back
	task automatic drain();
		while (advance_q.size() != 0 || in_valid || beam_q.size() != 0)
			@(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				beam_q.push_back(advance_beam(advance_cycles));
				gap_left = no_idle ? 0 : $urandom_range(0, 6);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (advance_q.size() != 0) begin
					advance_cycles <= advance_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (beam_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual total_count %0h",
						$time, total_count);
					errors++;
				end else begin
					want_r = beam_q.pop_front();
					cmp_field("total_count", want_r.total_count, total_count);
					cmp_field("line_number", 32'(want_r.line_number), 32'(line_number));
					cmp_field("line_position", 32'(want_r.line_position), 32'(line_position));
					cmp_field("in_vblank", 32'(want_r.in_vblank), 32'(in_vblank));
					cmp_field("in_hblank", 32'(want_r.in_hblank), 32'(in_hblank));
					cmp_field("until_hblank", 32'(want_r.until_hblank), 32'(until_hblank));
					cmp_field("until_vblank", 32'(want_r.until_vblank), 32'(until_vblank));
					cmp_field("until_video_event", 32'(want_r.until_video_event),
						32'(until_video_event));
					cmp_field("until_any_event", 32'(want_r.until_any_event),
						32'(until_any_event));
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 6);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0);
		end
	end

	initial begin
		logic [11:0] cpl, hbs;
		logic [7:0]  tl, vis;
		int          r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default timing: line wrap at exactly one line, then run into vblank
		advance_q.push_back(16'd0);
		advance_q.push_back(16'd1);
		advance_q.push_back(16'd959);
		advance_q.push_back(16'd1);
		advance_q.push_back(16'd270);
		advance_q.push_back(16'd1);
		repeat (4) advance_q.push_back(16'hFFFF);
		drain();

		// line now past the shortened frame, vblank distance clamps to zero
		set_timing(12'd1232, 12'd960, 8'd10, 8'd5);
		advance_q.push_back(16'd0);
		advance_q.push_back(16'd100);
		advance_q.push_back(16'hFFFF);
		drain();

		// zero line length and zero line count
		set_timing(12'd0, 12'd0, 8'd0, 8'd0);
		advance_q.push_back(16'd0);
		advance_q.push_back(16'd5);
		advance_q.push_back(16'hFFFF);
		drain();

		set_timing(12'hFFF, 12'hFFF, 8'hFF, 8'hFF);
		advance_q.push_back(16'hFFFF);
		advance_q.push_back(16'hFFFF);
		advance_q.push_back(16'd4094);
		advance_q.push_back(16'd1);
		drain();

		// hblank start beyond a one-cycle line
		set_timing(12'd1, 12'hFFF, 8'hFF, 8'd0);
		advance_q.push_back(16'hFFFF);
		advance_q.push_back(16'd3);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			cpl = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 16))
				: 12'($urandom_range(0, 4095));
			hbs = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 4095))
				: 12'($urandom_range(0, cpl));
			tl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8))
				: 8'($urandom_range(0, 255));
			vis = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, tl));
			set_timing(cpl, hbs, tl, vis);
			no_idle = (ph % 4 == 3);
			for (int n = 0; n < 140; n++) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					advance_q.push_back(16'd0);
				else if (r == 1)
					advance_q.push_back(16'hFFFF);
				else if (r <= 5)
					advance_q.push_back(16'($urandom_range(0, 2000)));
				else
					advance_q.push_back(16'($urandom));
			end
			drain();
		end
		no_idle = 1'b0;

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0 && beam_q.size() == 0)
			$display("** video_scanline_timing: PASSED **");
		else
			$display("** video_scanline_timing: FAILED **");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("** video_scanline_timing: FAILED **");
		$finish;
	end

endmodule

/* video_scanline_timing.f */
rtl/vst_pkg.sv
rtl/vst_div.sv
rtl/video_scanline_timing.sv
verif/testbench.sv
